// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication
`define MAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// mau_pkg
// Shared command codes, widths and the engine result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mau_pkg;

    localparam int ResW = 30;
    localparam int ModW = 31;
    localparam int WideW = 64;

    localparam logic [ModW-1:0] MOD_MIN = 31'd2;
    localparam logic [ModW-1:0] MOD_MAX = 31'h4000_0000;

    localparam logic [2:0] CMD_REDUCE = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_SUB    = 3'd2;
    localparam logic [2:0] CMD_MUL    = 3'd3;
    localparam logic [2:0] CMD_DIV    = 3'd4;
    localparam logic [2:0] CMD_POWER  = 3'd5;
    localparam logic [2:0] CMD_INV    = 3'd6;
    localparam logic [2:0] CMD_NEG    = 3'd7;

    typedef struct packed {
        logic            done;
        logic            err;
        logic [ResW-1:0] result;
    } mau_res_t;

endpackage

`default_nettype wire

// ===== design/mau_engine.sv =====
// ----------------------------------------------------------------------------
// mau_engine
// Sequencer around shift/compare/subtract datapaths: serial reduction,
// interleaved modular multiply and shift-subtract extended Euclid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mau_engine
    import mau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        command,
    input  wire logic [ResW-1:0]   left,
    input  wire logic [ResW-1:0]   right,
    input  wire logic [WideW-1:0]  wide,
    input  wire logic [ModW-1:0]   modulus,
    input  wire logic              ack,
    output mau_res_t               eo,
    output logic                   idle
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_EUC  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_POW  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [1:0] PH_MAIN = 2'd0;
    localparam logic [1:0] PH_EXP  = 2'd1;
    localparam logic [1:0] PH_PMUL = 2'd2;
    localparam logic [1:0] PH_PSQ  = 2'd3;

    logic [2:0]              state_reg, state_next;
    logic [1:0]              phase_reg, phase_next;
    logic [2:0]              cmd_reg, cmd_next;
    logic [ResW-1:0]         l_reg, l_next;
    logic [ModW-1:0]         m_reg, m_next;
    logic [WideW-1:0]        e_reg, e_next;
    logic [ResW-1:0]         base_reg, base_next;
    logic [ResW-1:0]         racc_reg, racc_next;
    logic [WideW-1:0]        rval_reg, rval_next;
    logic [5:0]              rcnt_reg, rcnt_next;
    logic [ModW-1:0]         rem_reg, rem_next;
    logic [ModW-1:0]         rdiv_reg, rdiv_next;
    logic                    rneg_reg, rneg_next;
    logic [ResW-1:0]         ma_reg, ma_next;
    logic [ResW-1:0]         mb_reg, mb_next;
    logic [ResW-1:0]         macc_reg, macc_next;
    logic [4:0]              mcnt_reg, mcnt_next;
    logic [ModW-1:0]         ea_reg, ea_next;
    logic [ModW-1:0]         eb_reg, eb_next;
    logic signed [63:0]      eu_reg, eu_next;
    logic signed [63:0]      ev_reg, ev_next;
    logic [4:0]              ek_reg, ek_next;
    logic [ResW-1:0]         res_reg, res_next;
    logic                    err_reg, err_next;

    // serial reduction step
    logic [ModW:0]   red_t, red_r;
    logic [ModW-1:0] red_new, red_fin;

    // interleaved multiply step
    logic [ModW:0]   mul_t, mul_r;
    logic [ResW-1:0] prod;

    // Euclid shift-subtract step
    logic [61:0]        euc_bs;
    logic               euc_fit;
    logic [ModW-1:0]    euc_a;
    logic signed [63:0] euc_u;
    logic [63:0]        u_mag;

    // start-time decode
    logic            use_l, use_r, op_err;
    logic [ModW:0]   sum_t, sub_t;
    logic [WideW-1:0] w_mag;

    always_comb
    begin
        red_t   = {rem_reg, rval_reg[WideW-1]};
        red_r   = (red_t >= {1'b0, rdiv_reg}) ? red_t - {1'b0, rdiv_reg} : red_t;
        red_new = red_r[ModW-1:0];
        red_fin = (rneg_reg && red_new != '0) ? rdiv_reg - red_new : red_new;
    end

    always_comb
    begin
        mul_t = {1'b0, macc_reg, 1'b0} + (mb_reg[mcnt_reg] ? {2'b00, ma_reg} : '0);
        if (mul_t >= {m_reg, 1'b0})
            mul_r = mul_t - {m_reg, 1'b0};
        else if (mul_t >= {1'b0, m_reg})
            mul_r = mul_t - {1'b0, m_reg};
        else
            mul_r = mul_t;
        prod = mul_r[ResW-1:0];
    end

    always_comb
    begin
        euc_bs  = {31'd0, eb_reg} << ek_reg;
        euc_fit = euc_bs <= {31'd0, ea_reg};
        euc_a   = euc_fit ? ea_reg - euc_bs[ModW-1:0] : ea_reg;
        euc_u   = euc_fit ? eu_reg - (ev_reg <<< ek_reg) : eu_reg;
        u_mag   = ev_reg[63] ? 64'(-ev_reg) : 64'(ev_reg);
    end

    always_comb
    begin
        use_l = 1'b0;
        use_r = 1'b0;
        unique case (command)
            CMD_REDUCE: ;
            CMD_POWER, CMD_INV:
                use_r = 1'b1;
            CMD_NEG:
                use_l = 1'b1;
            default:
            begin
                use_l = 1'b1;
                use_r = 1'b1;
            end
        endcase
        op_err = (use_l && {1'b0, left} >= modulus) || (use_r && {1'b0, right} >= modulus);
        sum_t  = {2'b00, left} + {2'b00, right};
        sub_t  = {2'b00, left} + {1'b0, modulus} - {2'b00, right};
        w_mag  = wide[WideW-1] ? (~wide) + 64'd1 : wide;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        l_next     = l_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        base_next  = base_reg;
        racc_next  = racc_reg;
        rval_next  = rval_reg;
        rcnt_next  = rcnt_reg;
        rem_next   = rem_reg;
        rdiv_next  = rdiv_reg;
        rneg_next  = rneg_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        macc_next  = macc_reg;
        mcnt_next  = mcnt_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        eu_next    = eu_reg;
        ev_next    = ev_reg;
        ek_next    = ek_reg;
        res_next   = res_reg;
        err_next   = err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = command;
                    l_next    = left;
                    m_next    = modulus;
                    err_next  = 1'b0;
                    phase_next = PH_MAIN;
                    if (op_err)
                    begin
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        unique case (command)
                            CMD_REDUCE:
                            begin
                                rval_next  = w_mag;
                                rcnt_next  = '0;
                                rem_next   = '0;
                                rdiv_next  = modulus;
                                rneg_next  = wide[WideW-1];
                                state_next = S_RED;
                            end
                            CMD_ADD:
                            begin
                                res_next = (sum_t >= {1'b0, modulus}) ?
                                    ResW'(sum_t - {1'b0, modulus}) : ResW'(sum_t);
                                state_next = S_DONE;
                            end
                            CMD_SUB:
                            begin
                                res_next = (sub_t >= {1'b0, modulus}) ?
                                    ResW'(sub_t - {1'b0, modulus}) : ResW'(sub_t);
                                state_next = S_DONE;
                            end
                            CMD_MUL:
                            begin
                                ma_next    = left;
                                mb_next    = right;
                                macc_next  = '0;
                                mcnt_next  = 5'(ResW - 1);
                                state_next = S_MUL;
                            end
                            CMD_DIV, CMD_INV:
                            begin
                                ea_next    = {1'b0, right};
                                eb_next    = modulus;
                                eu_next    = 64'sd1;
                                ev_next    = 64'sd0;
                                ek_next    = 5'(ResW);
                                state_next = S_EUC;
                            end
                            CMD_POWER:
                            begin
                                racc_next = ResW'(1);
                                base_next = right;
                                if (wide[WideW-1])
                                begin
                                    rval_next  = w_mag;
                                    rcnt_next  = '0;
                                    rem_next   = '0;
                                    rdiv_next  = modulus - 31'd1;
                                    rneg_next  = 1'b1;
                                    phase_next = PH_EXP;
                                    state_next = S_RED;
                                end
                                else
                                begin
                                    e_next     = wide;
                                    state_next = S_POW;
                                end
                            end
                            default:
                            begin
                                res_next = (left == '0) ? '0 : ResW'(modulus - {1'b0, left});
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end
            end

            // one remainder bit per cycle, MSB first
            S_RED:
            begin
                rem_next  = red_new;
                rval_next = {rval_reg[WideW-2:0], 1'b0};
                rcnt_next = rcnt_reg + 6'd1;
                if (rcnt_reg == 6'(WideW - 1))
                begin
                    if (phase_reg == PH_EXP)
                    begin
                        e_next     = {33'd0, red_fin};
                        state_next = S_POW;
                    end
                    else if (cmd_reg == CMD_DIV)
                    begin
                        ma_next    = l_reg;
                        mb_next    = red_fin[ResW-1:0];
                        macc_next  = '0;
                        mcnt_next  = 5'(ResW - 1);
                        state_next = S_MUL;
                    end
                    else
                    begin
                        res_next   = red_fin[ResW-1:0];
                        state_next = S_DONE;
                    end
                end
            end

            // one quotient bit per cycle; coefficient follows along
            S_EUC:
            begin
                ea_next = euc_a;
                eu_next = euc_u;
                ek_next = ek_reg - 5'd1;
                if (ek_reg == '0)
                begin
                    ea_next = eb_reg;
                    eb_next = euc_a;
                    eu_next = ev_reg;
                    ev_next = euc_u;
                    ek_next = 5'(ResW);
                    if (euc_a == '0)
                    begin
                        // final coefficient is the old v; fold it into range
                        rval_next  = u_mag;
                        rcnt_next  = '0;
                        rem_next   = '0;
                        rdiv_next  = m_reg;
                        rneg_next  = ev_reg[63];
                        phase_next = PH_MAIN;
                        state_next = S_RED;
                    end
                end
            end

            // one multiplier bit per cycle, MSB first
            S_MUL:
            begin
                macc_next = prod;
                mcnt_next = mcnt_reg - 5'd1;
                if (mcnt_reg == '0)
                begin
                    unique case (phase_reg)
                        PH_PMUL:
                        begin
                            racc_next  = prod;
                            ma_next    = base_reg;
                            mb_next    = base_reg;
                            macc_next  = '0;
                            mcnt_next  = 5'(ResW - 1);
                            phase_next = PH_PSQ;
                        end
                        PH_PSQ:
                        begin
                            base_next  = prod;
                            e_next     = {1'b0, e_reg[WideW-1:1]};
                            state_next = S_POW;
                        end
                        default:
                        begin
                            res_next   = prod;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // square-and-multiply, exponent LSB first
            S_POW:
            begin
                ma_next   = e_reg[0] ? racc_reg : base_reg;
                mb_next   = base_reg;
                macc_next = '0;
                mcnt_next = 5'(ResW - 1);
                if (e_reg == '0)
                begin
                    res_next   = racc_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    phase_next = e_reg[0] ? PH_PMUL : PH_PSQ;
                    state_next = S_MUL;
                end
            end

            S_DONE:
            begin
                if (ack)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_MAIN;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        l_reg    <= l_next;
        m_reg    <= m_next;
        e_reg    <= e_next;
        base_reg <= base_next;
        racc_reg <= racc_next;
        rval_reg <= rval_next;
        rcnt_reg <= rcnt_next;
        rem_reg  <= rem_next;
        rdiv_reg <= rdiv_next;
        rneg_reg <= rneg_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        macc_reg <= macc_next;
        mcnt_reg <= mcnt_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        eu_reg   <= eu_next;
        ev_reg   <= ev_next;
        ek_reg   <= ek_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign eo.done   = (state_reg == S_DONE);
    assign eo.err    = err_reg;
    assign eo.result = res_reg;

    `MAU_ASSERT_IMP(a_res_in_range, state_reg == S_DONE, {1'b0, res_reg} < m_reg)
    `MAU_ASSERT_IMP(a_mul_acc_range, state_reg == S_MUL, {1'b0, macc_reg} < m_reg)
    `MAU_ASSERT_IMP(a_red_rem_range, state_reg == S_RED, rem_reg < rdiv_reg)
    `MAU_ASSERT_NXT(a_done_holds, state_reg == S_DONE && !ack, state_reg == S_DONE)

endmodule

`default_nettype wire

// ===== design/modular_arithmetic_unit_top.sv =====
// Throughput: one beat at a time; the next beat is taken once the result is
// handed to the output register. Reset: async active low, modulus back to 2.
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_top
// Modulus register, input and output handshake around the engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module modular_arithmetic_unit_top
    import mau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [ModW-1:0]   cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        command,
    input  wire logic [ResW-1:0]   left,
    input  wire logic [ResW-1:0]   right,
    input  wire logic [WideW-1:0]  wide,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ResW-1:0]        result,
    output logic                   operand_error
);

    logic [ModW-1:0] modulus_reg;
    logic [ModW-1:0] mod_eff;
    logic            out_valid_reg, out_valid_next;
    logic [ResW-1:0] result_reg;
    logic            err_reg;
    logic            eng_idle, load;
    mau_res_t        eo;

    // clamp modulus into its legal range
    always_comb
    begin
        if (modulus_reg < MOD_MIN)
            mod_eff = MOD_MIN;
        else if (modulus_reg > MOD_MAX)
            mod_eff = MOD_MAX;
        else
            mod_eff = modulus_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MOD_MIN;
        else if (cfg_write)
            modulus_reg <= cfg_data;
    end

    mau_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_valid && eng_idle),
        .command (command),
        .left    (left),
        .right   (right),
        .wide    (wide),
        .modulus (mod_eff),
        .ack     (load),
        .eo      (eo),
        .idle    (eng_idle)
    );

    // output register
    assign load = eo.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= eo.result;
            err_reg    <= eo.err;
        end
    end

    assign in_stall      = !eng_idle;
    assign out_valid     = out_valid_reg;
    assign result        = result_reg;
    assign operand_error = err_reg;

    `MAU_ASSERT_IMP(a_err_zero, out_valid_reg && err_reg, result_reg == '0)

endmodule

`default_nettype wire

// ===== tb/sv/tb_modular_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// tb_modular_arithmetic_unit_top
// Self-checking bench for the modular arithmetic unit: a directed table of
// beats, then random beats under several idling phases and modulus settings,
// each result checked in order against a behavioral residue predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modular_arithmetic_unit_top
    import mau_pkg::*;
();

    localparam int WatchdogLimit = 200000;
    localparam int RandomBeats = 116;

    typedef struct {
        logic [2:0]        cmd;
        logic [ResW-1:0]   lhs;
        logic [ResW-1:0]   rhs;
        logic [WideW-1:0]  wval;
        bit                typed;
        logic [ResW-1:0]   want_res;
        logic              want_err;
    } vec_t;

    typedef struct {
        logic [ResW-1:0] res;
        logic            err;
    } residue_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [ModW-1:0]   cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [2:0]        command = CMD_REDUCE;
    logic [ResW-1:0]   left = '0;
    logic [ResW-1:0]   right = '0;
    logic [WideW-1:0]  wide = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ResW-1:0]   result;
    logic              operand_error;

    logic [ModW-1:0]   modulus_reg = 31'd2;
    residue_t          pending_residues[$];
    int                fail_count = 0;
    int                idle_cycles = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    bit                hold_off = 1'b0;
    int                hold_off_cycles = 0;

    modular_arithmetic_unit_top i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .command(command),
        .left(left), .right(right), .wide(wide), .out_valid(out_valid),
        .out_stall(out_stall), .result(result), .operand_error(operand_error)
    );

    always #6 clk = ~clk;

    // Residue predictor
    function automatic longint unsigned eff_modulus(logic [ModW-1:0] raw);
        if (raw < MOD_MIN) return 2;
        if (raw > MOD_MAX) return 64'h4000_0000;
        return raw;
    endfunction

    function automatic longint unsigned inverse_of(longint unsigned x, longint unsigned m);
        longint a, b, u, v, q, tmp;
        a = x; b = m; u = 1; v = 0;
        while (b > 0)
        begin
            q = a / b;
            a = a - q * b;
            tmp = a; a = b; b = tmp;
            u = u - q * v;
            tmp = u; u = v; v = tmp;
        end
        if (u >= 0) return longint'(u) % m;
        return (m - (longint'(-u) % m)) % m;
    endfunction

    function automatic longint unsigned power_of(longint unsigned base,
                                                 logic [63:0] e, longint unsigned m);
        longint unsigned acc, mag, n1;
        acc = 1 % m;
        if (e[63])
        begin
            mag = ~e + 64'd1;
            n1 = m - 1;
            e = (n1 - mag % n1) % n1;
        end
        while (e != 0)
        begin
            if (e[0]) acc = (acc * base) % m;
            base = (base * base) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic residue_t predict_residue(logic [2:0] cmd, logic [ResW-1:0] lhs,
                                                 logic [ResW-1:0] rhs, logic [63:0] w);
        longint unsigned m, l, r, x;
        bit use_l, use_r;
        residue_t o;
        m = eff_modulus(modulus_reg);
        l = lhs; r = rhs;
        use_l = cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_NEG};
        use_r = cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POWER, CMD_INV};
        o.err = 1'b0;
        if ((use_l && l >= m) || (use_r && r >= m))
        begin
            o.res = '0;
            o.err = 1'b1;
            return o;
        end
        case (cmd)
            CMD_REDUCE: x = w[63] ? (m - ((~w + 64'd1) % m)) % m : w % m;
            CMD_ADD:    x = (l + r) % m;
            CMD_SUB:    x = (l + m - r) % m;
            CMD_MUL:    x = (l * r) % m;
            CMD_DIV:    x = (l * inverse_of(r, m)) % m;
            CMD_POWER:  x = power_of(r, w, m);
            CMD_INV:    x = inverse_of(r, m);
            default:    x = (m - l) % m;
        endcase
        o.res = x[ResW-1:0];
        return o;
    endfunction

    // Watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("FAIL modular_arithmetic_unit_top");
            $finish;
        end
    end

    // Receiver: random stalls, or a long counted hold-off
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            out_stall <= 1'b1;
            if (hold_off_cycles >= 400)
            begin
                hold_off <= 1'b0;
                hold_off_cycles <= 0;
            end
            else
                hold_off_cycles <= hold_off_cycles + 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        residue_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_residues.size() == 0)
            begin
                $error("result beat with no expectation");
                fail_count++;
            end
            else
            begin
                exp_r = pending_residues.pop_front();
                if (result !== exp_r.res)
                begin
                    $error("result: expected %0d, actual %0d", exp_r.res, result);
                    fail_count++;
                end
                if (operand_error !== exp_r.err)
                begin
                    $error("operand_error: expected %0d, actual %0d", exp_r.err,
                           operand_error);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_modulus(logic [ModW-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        modulus_reg = value;
    endtask

    task automatic wait_drained();
        while (pending_residues.size() != 0) @(posedge clk);
        repeat (4200) @(posedge clk);
    endtask

    // Send one beat; optional typed-in expectation is checked against the predictor
    task automatic send_beat(vec_t v);
        residue_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(posedge clk);
            in_valid <= 1'b0;
        end
        @(posedge clk);
        in_valid <= 1'b1;
        command <= v.cmd;
        left <= v.lhs;
        right <= v.rhs;
        wide <= v.wval;
        p = predict_residue(v.cmd, v.lhs, v.rhs, v.wval);
        if (v.typed && (p.res !== v.want_res || p.err !== v.want_err))
        begin
            $error("table row: expected %0d/%0d, predictor %0d/%0d",
                   v.want_res, v.want_err, p.res, p.err);
            fail_count++;
        end
        pending_residues.push_back(p);
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
    endtask

    function automatic vec_t row(logic [2:0] c, longint unsigned l, longint unsigned r,
                                 logic [63:0] w, bit t, longint unsigned er, bit ee);
        vec_t v;
        v.cmd = c; v.lhs = ResW'(l); v.rhs = ResW'(r); v.wval = w;
        v.typed = t; v.want_res = ResW'(er); v.want_err = ee;
        return v;
    endfunction

    function automatic logic [ResW-1:0] pick_residue(longint unsigned m);
        case ($urandom_range(9))
            0: return ResW'($urandom);
            1: return ResW'(m - 1);
            2: return '0;
            default: return ResW'($urandom % m);
        endcase
    endfunction

    function automatic vec_t random_beat();
        longint unsigned m;
        vec_t v;
        m = eff_modulus(modulus_reg);
        v.cmd = 3'($urandom_range(7));
        v.lhs = pick_residue(m);
        v.rhs = pick_residue(m);
        v.wval = {$urandom, $urandom};
        // keep most exponents short so power stays quick
        if (v.cmd == CMD_POWER && $urandom_range(3) != 0)
            v.wval = $signed(v.wval) >>> $urandom_range(63, 40);
        v.typed = 1'b0;
        return v;
    endfunction

    vec_t directed_rows[$];

    initial
    begin
        logic [ModW-1:0] mod_set[6];
        int k;
        mod_set = '{31'd2, 31'd7, 31'h7FFF_FFFF, 31'd1000003, 31'd0, 31'd97};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset modulus of 2
        directed_rows.push_back(row(CMD_ADD, 1, 1, 0, 1, 0, 0));
        directed_rows.push_back(row(CMD_NEG, 2, 0, 0, 1, 0, 1));
        directed_rows.push_back(row(CMD_REDUCE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0));
        foreach (directed_rows[i]) send_beat(directed_rows[i]);
        wait_drained();

        // Prime modulus 13: every command, errors, zero inverse, negative exponent
        write_modulus(31'd13);
        directed_rows.delete();
        directed_rows.push_back(row(CMD_REDUCE, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0));
        directed_rows.push_back(row(CMD_REDUCE, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0));
        directed_rows.push_back(row(CMD_ADD, 12, 12, 0, 1, 11, 0));
        directed_rows.push_back(row(CMD_SUB, 0, 12, 0, 1, 1, 0));
        directed_rows.push_back(row(CMD_MUL, 12, 12, 0, 1, 1, 0));
        directed_rows.push_back(row(CMD_DIV, 5, 0, 0, 1, 0, 0));
        directed_rows.push_back(row(CMD_DIV, 6, 3, 0, 1, 2, 0));
        directed_rows.push_back(row(CMD_POWER, 0, 0, 0, 1, 1, 0));
        directed_rows.push_back(row(CMD_POWER, 0, 2, 64'hFFFF_FFFF_FFFF_FFFF, 1, 7, 0));
        directed_rows.push_back(row(CMD_POWER, 0, 12, 64'h8000_0000_0000_0000, 0, 0, 0));
        directed_rows.push_back(row(CMD_INV, 0, 0, 0, 1, 0, 0));
        directed_rows.push_back(row(CMD_INV, 0, 2, 0, 1, 7, 0));
        directed_rows.push_back(row(CMD_NEG, 0, 0, 0, 1, 0, 0));
        directed_rows.push_back(row(CMD_NEG, 1, 30'h3FFF_FFFF, 0, 1, 12, 0));
        directed_rows.push_back(row(CMD_ADD, 13, 0, 0, 1, 0, 1));
        directed_rows.push_back(row(CMD_INV, 30'h3FFF_FFFF, 13, 0, 1, 0, 1));
        directed_rows.push_back(row(CMD_MUL, 30'h3FFF_FFFF, 1, 0, 1, 0, 1));
        foreach (directed_rows[i]) send_beat(directed_rows[i]);
        wait_drained();

        // Non-coprime inverse, then modulus at the top of range
        write_modulus(31'd12);
        send_beat(row(CMD_INV, 0, 8, 0, 0, 0, 0));
        send_beat(row(CMD_DIV, 5, 6, 0, 0, 0, 0));
        wait_drained();
        write_modulus(31'h4000_0000);
        send_beat(row(CMD_MUL, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 0, 1, 1, 0));
        send_beat(row(CMD_ADD, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 0, 0, 0, 0));
        wait_drained();

        // Random phases: idling profiles crossed with modulus settings
        for (k = 0; k < RandomBeats; k++)
        begin
            if (k % 24 == 0)
            begin
                wait_drained();
                write_modulus(mod_set[(k / 24) % 6]);
                case ((k / 24) % 4)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 59; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 59; end
                    default: begin send_idle_pct = 27; stall_pct = 27; end
                endcase
                // long receiver hold-off while the sender keeps offering
                if (k == 48) hold_off = 1'b1;
            end
            send_beat(random_beat());
            // sender pause until everything has come back
            if (k == 70) while (pending_residues.size() != 0) @(posedge clk);
        end

        wait_drained();
        if (fail_count == 0)
            $display("PASS modular_arithmetic_unit_top");
        else
            $display("FAIL modular_arithmetic_unit_top");
        $finish;
    end

endmodule

`default_nettype wire
